FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

   localparam int DEF_MAX_COLUMNS = 80;
   localparam int DEF_MAX_ROWS    = 25;

   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int AMT_W      = 11;
   localparam int MODE_W     = 2;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int LOC_W      = 11;
   localparam int COLOR_W    = 8;
   localparam int COLS_W     = 7;
   localparam int ROWS_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_PUT_CHAR = 2'd0;
   localparam logic [OP_W-1:0] OP_SEEK     = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
   localparam logic [OP_W-1:0] OP_READ     = 2'd3;

   localparam logic [MODE_W-1:0] SEEK_ABS = 2'd0;
   localparam logic [MODE_W-1:0] SEEK_END = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS          = 2'd3;

   localparam logic [CHAR_W-1:0]  CH_NEWLINE    = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_TAB        = 8'd9;
   localparam logic [CHAR_W-1:0]  CH_SPACE      = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR   = 8'h07;
   localparam logic               RESET_SCROLL  = 1'b1;
   localparam logic [COLS_W-1:0]  RESET_COLUMNS = 7'd80;
   localparam logic [ROWS_W-1:0]  RESET_ROWS    = 5'd25;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [CHAR_W-1:0]  code;
   } cell_type;

endpackage

FILE: rtl/core/text_console_writer.sv
// Text console engine: a cell store of character/attribute pairs and a cursor.
// Items enter on the req_ channel (valid/ready); each item gives exactly one
// beat on the rsp_ channel with the cursor after the operation. Registers are
// written through the csr_ port while the block is idle: the user is bound to
// this, and the block itself does not enforce it. Each item passes S_PREP and
// S_EXEC, then S_WRITE when put_char writes a cell, S_RDWAIT for an in-range
// read_cell or S_DIV (the serial divider) for set_position, and ends in S_DONE.
// A scroll walks the cell store through its single read and single write port,
// copying each row up and then filling the last row; clear fills every cell of
// the screen. Items are handled one at a time; the next is taken once the previous result sits in the output register.
// After reset the block clears all MAX_COLUMNS*MAX_ROWS cells to space with
// attribute 7; req_ready stays low meanwhile.
// When the receiver stalls, the result holds in the output register and one
// more item may be accepted; it waits at the end until the register frees.
module text_console_writer #(
   parameter int MAX_COLUMNS = tcw_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcw_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tcw_pkg::OP_W-1:0]          req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::AMT_W-1:0]         req_seek_amount,
   input  logic [tcw_pkg::MODE_W-1:0]        req_seek_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcw_pkg::ROW_OUT_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::LOC_W-1:0]         rsp_cursor_location,
   output logic [tcw_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tcw_pkg::COLOR_W-1:0]       rsp_cell_color,
   output logic                              rsp_scrolled,
   output logic                              rsp_off_screen,
   input  logic                              csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import tcw_pkg::*;

   localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int LW    = RW + CW;
   localparam int SW    = ((LW > AMT_W) ? LW : AMT_W) + 1;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_PREP   = 4'd2;
   localparam logic [3:0] S_EXEC   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_RDWAIT = 4'd5;
   localparam logic [3:0] S_COPY   = 4'd6;
   localparam logic [3:0] S_FILL   = 4'd7;
   localparam logic [3:0] S_WRITE  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   // configuration
   logic [COLOR_W-1:0] color_ff;
   logic               scroll_ff;
   logic [COLS_W-1:0]  columns_ff;
   logic [ROWS_W-1:0]  rows_ff;
   logic [CW-1:0]      cols_eff;
   logic [RW-1:0]      rows_eff;
   logic [RW-1:0]      rlast;
   logic [PW-1:0]      total_ff;
   logic [PW-1:0]      copy_ff;

   // sequencer
   logic [3:0]         state_ff, state_in;
   logic [PW-1:0]      cnt_ff, cnt_in;
   logic               rv_ff, rv_in;
   logic [AW-1:0]      wa_ff, wa_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [LW-1:0]      loc_ff, loc_in;
   logic [RW-1:0]      wrow_ff, wrow_in;
   logic [CW-1:0]      wcol_ff, wcol_in;
   logic               wr_pend_ff, wr_pend_in;
   logic               post_ff, post_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CHAR_W-1:0]  ch_ff, ch_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               scr_ff, scr_in;
   logic               off_ff, off_in;
   cell_type           cell_ff, cell_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [LOC_W-1:0]     rsp_loc_ff, rsp_loc_in;
   cell_type             rsp_cell_ff, rsp_cell_in;
   logic                 rsp_scr_ff, rsp_scr_in;
   logic                 rsp_off_ff, rsp_off_in;

   // put_char decision
   logic [RW:0]   row1;
   logic          nl_wrap;
   logic          a_wrap;
   logic [RW-1:0] ra;
   logic [CW-1:0] ca;
   logic          sc_a, sc_b, pre, drop, ra_full;
   logic [RW-1:0] wr;
   logic [CW-1:0] wc;
   logic [CW:0]   wc1;
   logic [RW:0]   wr1;
   logic          post_wrap, wr_wrap, post;
   logic [RW-1:0] frow;
   logic [CW-1:0] fcol;

   // seek and read
   logic [SW-1:0] tot_ext, amt_ext, tgt;
   logic [PW-1:0] cpos;
   logic          rd_ok;
   logic [RW-1:0] row_clamp;
   logic [LW-1:0] prep_loc, cur_loc;
   logic [CHAR_W-1:0] ch_eff;

   // memory ports
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   cell_type      mem_wdata, mem_rdata;

   logic          div_start;
   logic          div_done;
   logic [RW-1:0] div_q;
   logic [PW-1:0] div_rem;

   always_comb begin
      if (columns_ff == '0) begin
         cols_eff = CW'(1);
      end else if (columns_ff > MAX_COLUMNS) begin
         cols_eff = CW'(MAX_COLUMNS);
      end else begin
         cols_eff = CW'(columns_ff);
      end
      if (rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (rows_ff > MAX_ROWS) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_ff);
      end
   end

   assign rlast = rows_eff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff   <= RESET_COLOR;
         scroll_ff  <= RESET_SCROLL;
         columns_ff <= RESET_COLUMNS;
         rows_ff    <= RESET_ROWS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEXT_COLOR:    color_ff   <= csr_wdata;
            CSR_SCROLL_ENABLE: scroll_ff  <= csr_wdata[0];
            CSR_COLUMNS:       columns_ff <= csr_wdata[COLS_W-1:0];
            CSR_ROWS:          rows_ff    <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
      total_ff <= PW'(LW'(rows_eff) * LW'(cols_eff));
      copy_ff  <= PW'(LW'(rlast) * LW'(cols_eff));
   end

   // put_char: optional scroll before the write, the write, optional scroll after
   always_comb begin
      row1    = {1'b0, row_ff} + 1'b1;
      nl_wrap = row1 >= {1'b0, rows_eff};
      a_wrap  = (col_ff >= cols_eff) && (row_ff < rows_eff);
      sc_a    = 1'b0;
      ra      = row_ff;
      ca      = col_ff;
      if (a_wrap) begin
         ca = '0;
         if (nl_wrap) begin
            if (scroll_ff) begin
               ra   = rlast;
               sc_a = 1'b1;
            end else begin
               ra = rows_eff;
            end
         end else begin
            ra = RW'(row1);
         end
      end
      ra_full   = ra >= rows_eff;
      sc_b      = ra_full && scroll_ff && !sc_a;
      drop      = ra_full && !scroll_ff;
      pre       = sc_a || sc_b;
      wr        = pre ? rlast : ra;
      wc        = pre ? '0 : ca;
      wc1       = {1'b0, wc} + 1'b1;
      wr1       = {1'b0, wr} + 1'b1;
      post_wrap = wc1 >= {1'b0, cols_eff};
      wr_wrap   = wr1 >= {1'b0, rows_eff};
      post      = post_wrap && wr_wrap && scroll_ff;
      if (post_wrap) begin
         fcol = '0;
         if (wr_wrap) begin
            frow = scroll_ff ? rlast : rows_eff;
         end else begin
            frow = RW'(wr1);
         end
      end else begin
         fcol = CW'(wc1);
         frow = wr;
      end
   end

   always_comb begin
      tot_ext = SW'(total_ff);
      amt_ext = SW'(amt_ff);
      case (mode_ff)
         SEEK_ABS: tgt = amt_ext;
         SEEK_END: tgt = (amt_ext > tot_ext) ? tot_ext : tot_ext - amt_ext;
         default:  tgt = SW'(loc_ff) + amt_ext;
      endcase
      cpos  = (tgt > tot_ext) ? total_ff : PW'(tgt);
      rd_ok = amt_ext < tot_ext;
   end

   assign row_clamp = (row_ff > rows_eff) ? rows_eff : row_ff;
   assign prep_loc  = LW'(row_clamp) * LW'(cols_eff) + LW'(col_ff);
   assign cur_loc   = LW'(row_ff) * LW'(cols_eff) + LW'(col_ff);
   assign ch_eff    = (ch_ff == CH_TAB) ? CH_SPACE : ch_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(cnt_ff);
      mem_wdata = '{color: color_ff, code: CH_SPACE};
      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '{color: RESET_COLOR, code: CH_SPACE};
         end
         S_COPY: begin
            mem_we    = rv_ff;
            mem_waddr = wa_ff;
            mem_wdata = mem_rdata;
         end
         S_FILL: mem_we = 1'b1;
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(LW'(wrow_ff) * LW'(cols_eff) + LW'(wcol_ff));
            mem_wdata = '{color: color_ff, code: ch_eff};
         end
         default: ;
      endcase
      mem_raddr = (state_ff == S_EXEC) ? AW'(amt_ff) : AW'(cnt_ff + PW'(cols_eff));
   end

   assign req_ready = (state_ff == S_IDLE);
   assign div_start = (state_ff == S_EXEC) && (op_ff == OP_SEEK);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rv_in        = (state_ff == S_COPY) && (cnt_ff < copy_ff);
      wa_in        = AW'(cnt_ff);
      row_in       = row_ff;
      col_in       = col_ff;
      loc_in       = loc_ff;
      wrow_in      = wrow_ff;
      wcol_in      = wcol_ff;
      wr_pend_in   = wr_pend_ff;
      post_in      = post_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      amt_in       = amt_ff;
      mode_in      = mode_ff;
      scr_in       = scr_ff;
      off_in       = off_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_loc_in   = rsp_loc_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_off_in   = rsp_off_ff;

      unique case (state_ff)
         S_INIT: begin
            if (cnt_ff == PW'(CELLS - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               ch_in    = req_char_code;
               amt_in   = req_seek_amount;
               mode_in  = req_seek_mode;
               scr_in   = 1'b0;
               off_in   = 1'b0;
               cell_in  = '0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            row_in   = row_clamp;
            loc_in   = prep_loc;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_PUT_CHAR: begin
                  if (ch_ff == CH_NEWLINE) begin
                     col_in   = '0;
                     state_in = S_DONE;
                     if (nl_wrap) begin
                        if (scroll_ff) begin
                           row_in     = rlast;
                           scr_in     = 1'b1;
                           wr_pend_in = 1'b0;
                           post_in    = 1'b0;
                           cnt_in     = '0;
                           state_in   = S_COPY;
                        end else begin
                           row_in = rows_eff;
                        end
                     end else begin
                        row_in = RW'(row1);
                     end
                  end else if (drop) begin
                     row_in   = rows_eff;
                     col_in   = '0;
                     off_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     wrow_in = wr;
                     wcol_in = wc;
                     row_in  = frow;
                     col_in  = fcol;
                     post_in = post;
                     scr_in  = pre || post;
                     if (pre) begin
                        wr_pend_in = 1'b1;
                        cnt_in     = '0;
                        state_in   = S_COPY;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
               end
               OP_SEEK:  state_in = S_DIV;
               OP_CLEAR: begin
                  row_in     = '0;
                  col_in     = '0;
                  wr_pend_in = 1'b0;
                  cnt_in     = '0;
                  state_in   = S_FILL;
               end
               OP_READ:  state_in = rd_ok ? S_RDWAIT : S_DONE;
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               row_in   = div_q;
               col_in   = CW'(div_rem);
               state_in = S_DONE;
            end
         end
         S_RDWAIT: begin
            cell_in  = mem_rdata;
            state_in = S_DONE;
         end
         S_COPY: begin
            // read runs one row ahead of the write; last write lands on exit
            if (cnt_ff < copy_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (cnt_ff == total_ff - 1'b1) begin
               state_in = wr_pend_ff ? S_WRITE : S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WRITE: begin
            wr_pend_in = 1'b0;
            if (post_ff) begin
               post_in  = 1'b0;
               cnt_in   = '0;
               state_in = S_COPY;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_OUT_W'(row_ff);
               rsp_col_in   = COL_OUT_W'(col_ff);
               rsp_loc_in   = LOC_W'(cur_loc);
               rsp_cell_in  = cell_ff;
               rsp_scr_in   = scr_ff;
               rsp_off_in   = off_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rv_ff        <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rv_ff        <= rv_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wr_pend_ff   <= wr_pend_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wa_ff       <= wa_in;
      loc_ff      <= loc_in;
      wrow_ff     <= wrow_in;
      wcol_ff     <= wcol_in;
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      amt_ff      <= amt_in;
      mode_ff     <= mode_in;
      scr_ff      <= scr_in;
      off_ff      <= off_in;
      cell_ff     <= cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_loc_ff  <= rsp_loc_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_off_ff  <= rsp_off_in;
   end

   tcw_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tcw_div #(
      .NW (PW),
      .DW (CW),
      .QW (RW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cpos),
      .divisor  (cols_eff),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_rem)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_cell_char       = rsp_cell_ff.code;
   assign rsp_cell_color      = rsp_cell_ff.color;
   assign rsp_scrolled        = rsp_scr_ff;
   assign rsp_off_screen      = rsp_off_ff;

endmodule

FILE: rtl/core/tcw_ram.sv
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/tcw_div.sv
module tcw_div #(
   parameter int NW = 12,
   parameter int DW = 7,
   parameter int QW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NW-1:0]        dividend,
   input  logic [DW-1:0]        divisor,
   output logic                 done,
   output logic [QW-1:0]        quot,
   output logic [NW-1:0]        rem
);

   localparam int SW = DW + QW;
   localparam int TW = NW + SW;
   localparam int BW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [BW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic          ge;

   assign ge = TW'(rem_ff) >= TW'(dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = BW'(QW);
         rem_in  = dividend;
         dsh_in  = SW'(divisor) << (QW - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         // one quotient bit per cycle, most significant first
         if (ge) begin
            rem_in = NW'(TW'(rem_ff) - TW'(dsh_ff));
         end
         quot_in = QW'({quot_ff, ge});
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == BW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
